// ===== hw/rtl/ted_pkg.sv =====
// shared types, format codes and the utf-8 lead decode for the text encoding detector
package ted_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned FormatWidth = 2;
   localparam int unsigned LeftWidth   = 3;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [FormatWidth-1:0] format_type;
   typedef logic [LeftWidth-1:0]   left_type;

   localparam format_type FMT_ASCII   = 2'd0;
   localparam format_type FMT_UTF8    = 2'd1;
   localparam format_type FMT_GBK     = 2'd2;
   localparam format_type FMT_UNKNOWN = 2'd3;

   localparam byte_type GBK_LEAD_LO  = 8'h81;
   localparam byte_type GBK_TRAIL_LO = 8'h40;
   localparam byte_type GBK_HI       = 8'hFE;

   // one input item as it sits in the input register
   typedef struct packed {
      byte_type data_byte;
      logic     no_byte;
      logic     last_byte;
   } item_type;

   typedef struct packed {
      logic     valid;
      left_type len;
   } utf8_lead_type;

   // continuation bytes owed after a utf-8 lead (old forms, up to six bytes)
   function automatic utf8_lead_type utf8_lead(input byte_type b);
      utf8_lead_type r;
      r.valid = 1'b1;
      r.len   = '0;
      if ((b & 8'hFE) == 8'hFC) begin
         r.len = 3'd5;
      end else if ((b & 8'hFC) == 8'hF8) begin
         r.len = 3'd4;
      end else if ((b & 8'hF8) == 8'hF0) begin
         r.len = 3'd3;
      end else if ((b & 8'hF0) == 8'hE0) begin
         r.len = 3'd2;
      end else if ((b & 8'hE0) == 8'hC0) begin
         r.len = 3'd1;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/ted_if.sv =====
// valid/ready channel interfaces for the detector's byte input and format output
interface ted_req_if;
   logic                 valid;
   logic                 ready;
   ted_pkg::byte_type    data_byte;
   logic                 no_byte;
   logic                 last_byte;

   modport source (output valid, output data_byte, output no_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input no_byte, input last_byte,
                   output ready);
endinterface

interface ted_rsp_if;
   logic                 valid;
   logic                 ready;
   ted_pkg::format_type  format;

   modport source (output valid, output format, input ready);
   modport sink   (input valid, input format, output ready);
endinterface

// ===== hw/rtl/text_encoding_detector.sv =====
// top level of the text encoding detector: input register, validators, result register
//
//   channel  dir  transfer                          payload
//   req_bus  in   one byte of the string            data_byte[7:0], no_byte, last_byte
//   rsp_bus  out  one verdict per string            format[1:0]
//
// one byte per cycle unless the input register holds its byte; the verdict for a
// string is loaded into the result register at the edge its last item leaves the
// input register, and rsp_bus.valid comes straight from the result register.
// synchronous active-high reset clears both valid flags and the validator state.
// while a verdict waits, non-last bytes keep flowing; only a second last item holds.
module text_encoding_detector (
   input  logic          clock,
   input  logic          reset,
   ted_req_if.sink       req_bus,
   ted_rsp_if.source     rsp_bus
);

   logic                 req_valid_ff;
   ted_pkg::item_type    req_item_ff;
   logic                 rsp_valid_ff;
   ted_pkg::format_type  rsp_format_ff;
   ted_pkg::format_type  format;
   logic                 out_free;
   logic                 advance;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = req_valid_ff && (!req_item_ff.last_byte || out_free);
   assign req_bus.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         req_item_ff.data_byte <= req_bus.data_byte;
         req_item_ff.no_byte   <= req_bus.no_byte;
         req_item_ff.last_byte <= req_bus.last_byte;
      end
   end

   ted_check u_check (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .format  (format)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && req_item_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_item_ff.last_byte) begin
         rsp_format_ff <= format;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.format = rsp_format_ff;

endmodule

// ===== hw/rtl/ted_check.sv =====
// ascii, utf-8 and gbk validator state with the per-byte update and the final verdict
module ted_check (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ted_pkg::item_type   item,
   output ted_pkg::format_type format
);

   logic               ascii_ok_ff, ascii_ok_in;
   logic               utf8_ok_ff, utf8_ok_in;
   ted_pkg::left_type  utf8_left_ff, utf8_left_in;
   logic               gbk_ok_ff, gbk_ok_in;
   logic               gbk_want_ff, gbk_want_in;
   ted_pkg::utf8_lead_type lead;
   ted_pkg::byte_type  b;

   assign b    = item.data_byte;
   assign lead = ted_pkg::utf8_lead(b);

   always_comb begin
      ascii_ok_in  = ascii_ok_ff;
      utf8_ok_in   = utf8_ok_ff;
      utf8_left_in = utf8_left_ff;
      gbk_ok_in    = gbk_ok_ff;
      gbk_want_in  = gbk_want_ff;
      if (!item.no_byte) begin
         if (b[7]) begin
            ascii_ok_in = 1'b0;
         end
         if (utf8_ok_ff) begin
            if (utf8_left_ff != '0) begin
               if (b[7:6] != 2'b10) begin
                  utf8_ok_in = 1'b0;
               end else begin
                  utf8_left_in = utf8_left_ff - 3'd1;
               end
            end else if (b[7]) begin
               if (!lead.valid) begin
                  utf8_ok_in = 1'b0;
               end else begin
                  utf8_left_in = lead.len;
               end
            end
         end
         if (gbk_ok_ff) begin
            if (gbk_want_ff) begin
               if (b < ted_pkg::GBK_TRAIL_LO || b > ted_pkg::GBK_HI) begin
                  gbk_ok_in = 1'b0;
               end
               gbk_want_in = 1'b0;
            end else if (b[7]) begin
               if (b < ted_pkg::GBK_LEAD_LO || b > ted_pkg::GBK_HI) begin
                  gbk_ok_in = 1'b0;
               end else begin
                  gbk_want_in = 1'b1;
               end
            end
         end
      end
   end

   // a cut-off sequence at the end fails its validator
   always_comb begin
      if (ascii_ok_in) begin
         format = ted_pkg::FMT_ASCII;
      end else if (utf8_ok_in && utf8_left_in == '0) begin
         format = ted_pkg::FMT_UTF8;
      end else if (gbk_ok_in && !gbk_want_in) begin
         format = ted_pkg::FMT_GBK;
      end else begin
         format = ted_pkg::FMT_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         ascii_ok_ff  <= 1'b1;
         utf8_ok_ff   <= 1'b1;
         utf8_left_ff <= '0;
         gbk_ok_ff    <= 1'b1;
         gbk_want_ff  <= 1'b0;
      end else if (advance) begin
         ascii_ok_ff  <= ascii_ok_in;
         utf8_ok_ff   <= utf8_ok_in;
         utf8_left_ff <= utf8_left_in;
         gbk_ok_ff    <= gbk_ok_in;
         gbk_want_ff  <= gbk_want_in;
      end
   end

endmodule
